>>> src/lac_pkg.sv
// ----------------------------------------------------------------------------
// lac_pkg - shared types and constants for the LRU asset cache
// Widths, register decode, status codes and the beat structs used by the
// cache datapath and its top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lac_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 8;
   localparam int KEY_WIDTH_DEFAULT   = 32;

   localparam int ASSET_KEY_WIDTH = 32;
   localparam int SLOT_WIDTH      = 3;
   localparam int CAPACITY_WIDTH  = 4;

   localparam logic [CAPACITY_WIDTH-1:0] CAPACITY_RESET = 4'd5;

   // CSR: one 32-bit register per word, index taken from paddr[2]
   localparam int   CSR_ADDR_WIDTH   = 3;
   localparam int   CSR_DATA_WIDTH   = 32;
   localparam logic CSR_IDX_CAPACITY = 1'b0;

   typedef enum logic [1:0] {
      STATUS_HIT       = 2'd0,
      STATUS_INSERT    = 2'd1,
      STATUS_LOAD_FAIL = 2'd2
   } status_type;

   typedef struct packed {
      logic [ASSET_KEY_WIDTH-1:0] asset_key;
      logic                       load_ok;
   } request_type;

   typedef struct packed {
      status_type                 status;
      logic [SLOT_WIDTH-1:0]      slot;
      logic                       evicted;
      logic [ASSET_KEY_WIDTH-1:0] evicted_key;
   } result_type;

endpackage

`default_nettype wire

>>> src/lac_req_if.sv
// ----------------------------------------------------------------------------
// lac_req_if - lookup request channel
// Valid/ready channel carrying one asset key and its load flag per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lac_req_if;

   logic                                valid;
   logic                                ready;
   logic [lac_pkg::ASSET_KEY_WIDTH-1:0] asset_key;
   logic                                load_ok;

   modport source (output valid, output asset_key, output load_ok, input ready);
   modport sink   (input valid, input asset_key, input load_ok, output ready);

endinterface

`default_nettype wire

>>> src/lac_rsp_if.sv
// ----------------------------------------------------------------------------
// lac_rsp_if - lookup response channel
// Valid/ready channel carrying status, slot and eviction info per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lac_rsp_if;

   logic                                valid;
   logic                                ready;
   lac_pkg::status_type                 status;
   logic [lac_pkg::SLOT_WIDTH-1:0]      slot;
   logic                                evicted;
   logic [lac_pkg::ASSET_KEY_WIDTH-1:0] evicted_key;

   modport source (output valid, output status, output slot, output evicted,
                   output evicted_key, input ready);
   modport sink   (input valid, input status, input slot, input evicted,
                   input evicted_key, output ready);

endinterface

`default_nettype wire

>>> src/lru_asset_cache_unit.sv
// ----------------------------------------------------------------------------
// lru_asset_cache_unit - fully associative LRU cache of asset keys
// Request register, single-pass lookup/update, response register, CSR.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one lookup per beat: asset_key and load_ok (whether a
//   load on a miss succeeds). rsp_bus returns one beat per request, in order:
//   status (hit / inserted / load failed), slot, evicted and evicted_key.
//   CSR register 0 (byte address 0) is capacity, bits [3:0]; 0 acts as 1 and
//   values above MAX_ENTRIES act as MAX_ENTRIES. Write it only while idle.
// Timing:
//   A request beat lands in the input register, is looked up and committed
//   as it moves into the response register, which then presents its response.
//   One beat per cycle is sustained while rsp_bus is ready: the tag compare,
//   victim pick and rank update for all entries sit between the registers.
// Reset:
//   Synchronous reset empties the store, sets capacity to 5 and drops both
//   pipeline registers. No clearing pass is needed.
// Backpressure:
//   While rsp_bus is stalled the response register holds; the input register
//   keeps one more beat, then req_bus.ready drops until the response drains.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_asset_cache_unit #(
   parameter int MAX_ENTRIES = lac_pkg::MAX_ENTRIES_DEFAULT,
   parameter int KEY_WIDTH   = lac_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   lac_req_if.sink                            req_bus,
   lac_rsp_if.source                          rsp_bus,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [lac_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [lac_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [lac_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                               csr_pready
);

   logic                               in_valid_ff, in_valid_in;
   lac_pkg::request_type               in_req_ff;
   logic                               out_valid_ff, out_valid_in;
   lac_pkg::result_type                out_result_ff;
   lac_pkg::result_type                result;
   logic [lac_pkg::CAPACITY_WIDTH-1:0] capacity_ff, capacity_in;

   logic req_fire, advance, csr_write, csr_idx;

   always_comb begin
      advance     = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
      req_fire    = req_bus.valid && req_bus.ready;
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_bus.ready);
   end

   assign req_bus.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_req_ff.asset_key <= req_bus.asset_key;
         in_req_ff.load_ok   <= req_bus.load_ok;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   lac_store #(
      .MAX_ENTRIES (MAX_ENTRIES),
      .KEY_WIDTH   (KEY_WIDTH)
   ) u_store (
      .clock       (clock),
      .reset       (reset),
      .capacity    (capacity_ff),
      .lookup_fire (advance),
      .request     (in_req_ff),
      .result      (result)
   );

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.status      = out_result_ff.status;
   assign rsp_bus.slot        = out_result_ff.slot;
   assign rsp_bus.evicted     = out_result_ff.evicted;
   assign rsp_bus.evicted_key = out_result_ff.evicted_key;

   // CSR
   always_comb begin
      csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
      csr_idx     = csr_paddr[lac_pkg::CSR_ADDR_WIDTH-1];
      capacity_in = capacity_ff;
      if (csr_write && (csr_idx == lac_pkg::CSR_IDX_CAPACITY)) begin
         capacity_in = csr_pwdata[lac_pkg::CAPACITY_WIDTH-1:0];
      end
      csr_prdata = (csr_idx == lac_pkg::CSR_IDX_CAPACITY)
                 ? lac_pkg::CSR_DATA_WIDTH'(capacity_ff) : '0;
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= lac_pkg::CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

endmodule

`default_nettype wire

>>> src/lac_store.sv
// ----------------------------------------------------------------------------
// lac_store - tag store and recency ranks of the LRU asset cache
// Parallel key match, victim and free-slot selection, rank aging and the
// state update for one lookup, all in a single pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_store #(
   parameter int MAX_ENTRIES = lac_pkg::MAX_ENTRIES_DEFAULT,
   parameter int KEY_WIDTH   = lac_pkg::KEY_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [lac_pkg::CAPACITY_WIDTH-1:0] capacity,
   input  logic                               lookup_fire,
   input  lac_pkg::request_type               request,
   output lac_pkg::result_type                result
);

   localparam int IDX_W   = $clog2(MAX_ENTRIES);
   localparam int COUNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CMP_W   = (COUNT_W > lac_pkg::CAPACITY_WIDTH) ? COUNT_W
                                                                : lac_pkg::CAPACITY_WIDTH;

   logic [KEY_WIDTH-1:0]   keys_ff [MAX_ENTRIES];
   logic [MAX_ENTRIES-1:0] valid_ff, valid_in;
   logic [IDX_W-1:0]       rank_ff [MAX_ENTRIES];
   logic [IDX_W-1:0]       rank_in [MAX_ENTRIES];
   logic [COUNT_W-1:0]     count_ff, count_in;

   logic [KEY_WIDTH-1:0]   key;
   logic [KEY_WIDTH-1:0]   victim_key;
   logic [CMP_W-1:0]       cap_ext, cap_eff;
   logic                   full;
   logic [IDX_W-1:0]       lru_rank;
   logic [IDX_W-1:0]       hit_rank;
   logic [MAX_ENTRIES-1:0] hit_vec, victim_vec, key_we;
   logic [IDX_W-1:0]       hit_idx, victim_idx, free_idx, sel_idx;
   logic                   hit, do_insert, evict;

   always_comb begin
      key     = KEY_WIDTH'(request.asset_key);
      cap_ext = CMP_W'(capacity);
      if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CMP_W'(MAX_ENTRIES)) begin
         cap_eff = CMP_W'(MAX_ENTRIES);
      end else begin
         cap_eff = cap_ext;
      end
      full = (CMP_W'(count_ff) >= cap_eff);
      // valid ranks are a permutation of 0..count-1, so the LRU entry holds count-1
      lru_rank = IDX_W'(count_ff - COUNT_W'(1));

      hit_idx    = '0;
      victim_idx = '0;
      free_idx   = '0;
      hit_rank   = '0;
      victim_key = '0;
      for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
         hit_vec[i]    = valid_ff[i] && (keys_ff[i] == key);
         victim_vec[i] = valid_ff[i] && (rank_ff[i] == lru_rank);
         if (hit_vec[i]) begin
            hit_idx = IDX_W'(i);
         end
         if (victim_vec[i]) begin
            victim_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_idx = IDX_W'(i);
         end
      end

      // hit and victim are unique, so an OR mux is enough
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (hit_vec[i]) begin
            hit_rank = hit_rank | rank_ff[i];
         end
         if (victim_vec[i]) begin
            victim_key = victim_key | keys_ff[i];
         end
      end

      hit       = |hit_vec;
      do_insert = !hit && request.load_ok;
      evict     = do_insert && full;
      sel_idx   = hit ? hit_idx : (full ? victim_idx : free_idx);

      for (int i = 0; i < MAX_ENTRIES; i++) begin
         key_we[i]  = do_insert && (IDX_W'(i) == sel_idx);
         valid_in[i] = valid_ff[i] | key_we[i];
         rank_in[i]  = rank_ff[i];
         if (hit || do_insert) begin
            if (IDX_W'(i) == sel_idx) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && (do_insert || (rank_ff[i] < hit_rank))) begin
               rank_in[i] = rank_ff[i] + IDX_W'(1);
            end
         end
      end

      count_in = (do_insert && !full) ? count_ff + COUNT_W'(1) : count_ff;

      if (hit) begin
         result.status = lac_pkg::STATUS_HIT;
      end else if (request.load_ok) begin
         result.status = lac_pkg::STATUS_INSERT;
      end else begin
         result.status = lac_pkg::STATUS_LOAD_FAIL;
      end
      result.slot        = (hit || do_insert) ? lac_pkg::SLOT_WIDTH'(sel_idx) : '0;
      result.evicted     = evict;
      result.evicted_key = evict ? lac_pkg::ASSET_KEY_WIDTH'(victim_key) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else if (lookup_fire) begin
         valid_ff <= valid_in;
         count_ff <= count_in;
         for (int i = 0; i < MAX_ENTRIES; i++) begin
            rank_ff[i] <= rank_in[i];
         end
      end
   end

   // keys are only read behind a valid bit
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
         if (lookup_fire && key_we[i]) begin
            keys_ff[i] <= key;
         end
      end
   end

endmodule

`default_nettype wire

>>> src/lac_checker.sv
// ----------------------------------------------------------------------------
// lac_checker - port-level checks for the LRU asset cache
// Watches the response channel and reset behavior; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lac_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input lac_pkg::status_type                 rsp_status,
   input logic [lac_pkg::SLOT_WIDTH-1:0]      rsp_slot,
   input logic                                rsp_evicted,
   input logic [lac_pkg::ASSET_KEY_WIDTH-1:0] rsp_evicted_key
);

   // a stalled response beat stays valid with its status, slot and evicted key held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_slot)
                                  && $stable(rsp_evicted_key))
      else $error("response beat changed while stalled");

   // failed load leaves nothing behind
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == lac_pkg::STATUS_LOAD_FAIL)
         |-> (rsp_slot == '0) && !rsp_evicted && (rsp_evicted_key == '0))
      else $error("load failure reported a slot or an eviction");

   // eviction only on an insert; no key without an eviction
   a_evict_insert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_evicted || (rsp_evicted_key != '0))
         |-> rsp_evicted && (rsp_status == lac_pkg::STATUS_INSERT))
      else $error("eviction reported outside an insert");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind lru_asset_cache_unit lac_checker u_lac_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_status      (rsp_bus.status),
   .rsp_slot        (rsp_bus.slot),
   .rsp_evicted     (rsp_bus.evicted),
   .rsp_evicted_key (rsp_bus.evicted_key)
);

`default_nettype wire

>>> dv/lru_asset_cache_unit_tb.sv
// ----------------------------------------------------------------------------
// lru_asset_cache_unit_tb - self-checking bench for the LRU asset cache
// A queue-fed driver sends lookups on req_bus. Each accepted beat is run
// through a behavioral LRU cache model, and the predicted response is queued.
// A monitor compares every rsp_bus beat with the oldest prediction. Both
// sides idle at random, and capacity is rewritten between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_asset_cache_unit_tb;

   localparam int CACHE_DEPTH     = lac_pkg::MAX_ENTRIES_DEFAULT;
   localparam int ITEMS_PER_PHASE = 128;
   localparam int LONG_HOLD       = 64;
   localparam int STUCK_LIMIT     = 1000;

   localparam logic [lac_pkg::CSR_ADDR_WIDTH-1:0] CAPACITY_ADDR =
      {lac_pkg::CSR_IDX_CAPACITY, 2'b00};

   logic clock = 1'b0;
   logic reset;

   logic                               csr_psel;
   logic                               csr_penable;
   logic                               csr_pwrite;
   logic [lac_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [lac_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [lac_pkg::CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                               csr_pready;

   lac_req_if req_bus ();
   lac_rsp_if rsp_bus ();

   lru_asset_cache_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // cache model state
   logic [lac_pkg::ASSET_KEY_WIDTH-1:0] slot_key   [CACHE_DEPTH];
   logic                                slot_valid [CACHE_DEPTH];
   int                                  slot_rank  [CACHE_DEPTH];
   int                                  occupancy;
   logic [lac_pkg::CAPACITY_WIDTH-1:0]  cap_setting;

   lac_pkg::request_type                pending_lookups[$];
   lac_pkg::result_type                 predicted_results[$];
   logic [lac_pkg::ASSET_KEY_WIDTH-1:0] key_pool[$];

   int fail_count       = 0;
   int lookups_sent     = 0;
   int results_checked  = 0;
   int hits             = 0;
   int inserts          = 0;
   int evictions        = 0;
   int failed_loads     = 0;
   int settings_written = 0;
   int long_holds       = 0;

   int req_gap  = 0;
   int rsp_hold = 0;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;
   int stuck_cycles = 0;

   int cap_plan[11] = '{8, 1, 15, 3, 0, 6, 2, 9, 4, 7, 5};

   // ------------------------------------------------------------------------
   // LRU model
   // ------------------------------------------------------------------------
   function automatic void make_most_recent(input int s, input int old_rank);
      for (int i = 0; i < CACHE_DEPTH; i++)
         if (slot_valid[i] && i != s && slot_rank[i] < old_rank)
            slot_rank[i]++;
      slot_rank[s] = 0;
   endfunction

   function automatic lac_pkg::result_type lru_lookup(
      input logic [lac_pkg::ASSET_KEY_WIDTH-1:0] key,
      input logic                                load_ok);
      lac_pkg::result_type res;
      int cap_eff;
      int found;
      int victim;
      res.status      = lac_pkg::STATUS_HIT;
      res.slot        = '0;
      res.evicted     = 1'b0;
      res.evicted_key = '0;
      cap_eff = (cap_setting == 0) ? 1 :
                ((cap_setting > CACHE_DEPTH) ? CACHE_DEPTH : int'(cap_setting));
      found = -1;
      for (int i = 0; i < CACHE_DEPTH; i++)
         if (found < 0 && slot_valid[i] && slot_key[i] == key)
            found = i;
      if (found >= 0) begin
         make_most_recent(found, slot_rank[found]);
         res.slot = lac_pkg::SLOT_WIDTH'(found);
         hits++;
      end else if (!load_ok) begin
         res.status = lac_pkg::STATUS_LOAD_FAIL;
         failed_loads++;
      end else begin
         res.status = lac_pkg::STATUS_INSERT;
         victim = -1;
         if (occupancy >= cap_eff) begin
            // full (or over a lowered capacity): recycle the oldest slot
            for (int i = 0; i < CACHE_DEPTH; i++)
               if (slot_valid[i] && (victim < 0 || slot_rank[i] > slot_rank[victim]))
                  victim = i;
            res.evicted     = 1'b1;
            res.evicted_key = slot_key[victim];
            slot_key[victim] = key;
            make_most_recent(victim, slot_rank[victim]);
            evictions++;
         end else begin
            for (int i = 0; i < CACHE_DEPTH; i++)
               if (victim < 0 && !slot_valid[i])
                  victim = i;
            slot_valid[victim] = 1'b1;
            slot_key[victim]   = key;
            make_most_recent(victim, CACHE_DEPTH);
            occupancy++;
         end
         res.slot = lac_pkg::SLOT_WIDTH'(victim);
         inserts++;
      end
      return res;
   endfunction

   function automatic int draw_wait(input bit quiet);
      if (quiet || $urandom_range(0, 1) == 0)
         return 0;
      return $urandom_range(0, 15);
   endfunction

   function automatic logic [lac_pkg::ASSET_KEY_WIDTH-1:0] random_key();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return $urandom_range(0, 1) ? '0 : '1;
         default: return key_pool[$urandom_range(0, key_pool.size() - 1)];
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // request driver
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      lac_pkg::request_type next_req;
      bit offering;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_gap = 0;
      end else begin
         offering = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            predicted_results.push_back(lru_lookup(req_bus.asset_key, req_bus.load_ok));
            lookups_sent++;
            if (lookups_sent % 50 == 0)
               req_quiet = ($urandom_range(0, 3) == 0);
            req_gap  = draw_wait(req_quiet);
            offering = 1'b0;
         end
         if (!offering) begin
            if (req_gap == 0 && pending_lookups.size() != 0) begin
               next_req = pending_lookups.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.asset_key <= next_req.asset_key;
               req_bus.load_ok   <= next_req.load_ok;
            end else begin
               req_bus.valid <= 1'b0;
               if (req_gap > 0)
                  req_gap--;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // response monitor
   // ------------------------------------------------------------------------
   task automatic check_result();
      lac_pkg::result_type want;
      if (predicted_results.size() == 0) begin
         $error("response beat with no lookup outstanding");
         fail_count++;
         return;
      end
      want = predicted_results.pop_front();
      if (rsp_bus.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
         fail_count++;
      end
      if (rsp_bus.slot !== want.slot) begin
         $error("slot: expected %0d, got %0d", want.slot, rsp_bus.slot);
         fail_count++;
      end
      if (rsp_bus.evicted !== want.evicted) begin
         $error("evicted: expected %0d, got %0d", want.evicted, rsp_bus.evicted);
         fail_count++;
      end
      if (rsp_bus.evicted_key !== want.evicted_key) begin
         $error("evicted_key: expected %08h, got %08h", want.evicted_key,
                rsp_bus.evicted_key);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_result();
            results_checked++;
            if (results_checked % 50 == 0)
               rsp_quiet = ($urandom_range(0, 3) == 0);
            // long back-pressure while the sender still has plenty queued
            if (long_holds < 2 && results_checked >= 250 + 500 * long_holds &&
                pending_lookups.size() > 16) begin
               rsp_hold = LONG_HOLD;
               long_holds++;
            end else begin
               rsp_hold = draw_wait(rsp_quiet);
            end
         end
         if (rsp_hold > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // watchdog: cycles without any beat or CSR access
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_psel) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $error("no progress for %0d cycles, %0d responses outstanding",
                   STUCK_LIMIT, predicted_results.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   task automatic add_lookup(input logic [lac_pkg::ASSET_KEY_WIDTH-1:0] key,
                             input logic load_ok);
      lac_pkg::request_type r;
      r.asset_key = key;
      r.load_ok   = load_ok;
      pending_lookups.push_back(r);
   endtask

   task automatic wait_drained();
      while (pending_lookups.size() != 0 || req_bus.valid || predicted_results.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [lac_pkg::CSR_DATA_WIDTH-1:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CAPACITY_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      cap_setting = value[lac_pkg::CAPACITY_WIDTH-1:0];
      settings_written++;
   endtask

   initial begin
      int cap_eff;
      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_bus.valid     = 1'b0;
      req_bus.asset_key = '0;
      req_bus.load_ok   = 1'b0;
      rsp_bus.ready     = 1'b0;
      for (int i = 0; i < CACHE_DEPTH; i++) begin
         slot_key[i]   = '0;
         slot_valid[i] = 1'b0;
         slot_rank[i]  = 0;
      end
      occupancy   = 0;
      cap_setting = lac_pkg::CAPACITY_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset capacity: failed load on empty store, key 0, all-ones key,
      // fill to 5, then evict (the victim holds key 0) and hit/fail when full
      add_lookup(32'h0000_0000, 1'b0);
      add_lookup(32'h0000_0000, 1'b1);
      add_lookup(32'h0000_0000, 1'b0);
      add_lookup(32'hFFFF_FFFF, 1'b1);
      add_lookup(32'h0000_0001, 1'b1);
      add_lookup(32'h0000_0002, 1'b1);
      add_lookup(32'h0000_0003, 1'b1);
      add_lookup(32'h8000_0000, 1'b1);
      add_lookup(32'hFFFF_FFFF, 1'b0);
      add_lookup(32'h1234_5678, 1'b0);
      add_lookup(32'hAAAA_AAAA, 1'b1);
      add_lookup(32'h5555_5555, 1'b1);

      // zero capacity acts as one; upper data bits are ignored
      set_capacity(32'hFFFF_FFF0);
      add_lookup(32'hAAAA_AAAA, 1'b1);
      add_lookup(32'h0000_0007, 1'b1);
      add_lookup(32'h0000_0007, 1'b0);
      add_lookup(32'h0000_0008, 1'b0);

      // oversize capacity clamps to the store depth
      set_capacity(32'd15);
      add_lookup(32'h0000_0009, 1'b1);
      add_lookup(32'h0000_000A, 1'b1);
      add_lookup(32'h0000_000B, 1'b1);
      add_lookup(32'h0000_000C, 1'b1);

      // capacity dropped below the current count
      set_capacity(32'd2);
      add_lookup(32'h0000_000D, 1'b1);
      add_lookup(32'h0000_000E, 1'b0);

      // random phases, each with its own key pool sized to the capacity
      foreach (cap_plan[p]) begin
         set_capacity(($urandom() & 32'hFFFF_FFF0) | cap_plan[p]);
         cap_eff = (cap_plan[p] == 0) ? 1 :
                   ((cap_plan[p] > CACHE_DEPTH) ? CACHE_DEPTH : cap_plan[p]);
         key_pool.delete();
         repeat (2 * cap_eff + 2)
            key_pool.push_back($urandom());
         repeat (ITEMS_PER_PHASE)
            add_lookup(random_key(), $urandom_range(0, 6) != 0);
      end

      wait_drained();
      $display("%0d lookups: %0d hits, %0d inserts (%0d evicting), %0d failed loads",
               lookups_sent, hits, inserts, evictions, failed_loads);
      $display("%0d capacity writes, %0d long response stalls, %0d responses checked",
               settings_written, long_holds, results_checked);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
